// File: rtl/core/gf2m_fmi_pkg.sv
// shared types and constants for the gf2m field multiply / inverse core
package gf2m_fmi_pkg;

	// configuration port geometry
	localparam int CFG_DATA_W = 64;
	localparam int CFG_ADDR_W = 4;

	// register index, taken from paddr[3] (registers sit at 8-byte strides)
	localparam logic REG_MODULUS = 1'b0;

	// reset value of the reduction polynomial
	localparam logic [32:0] MOD_RESET = 33'h1_0000_008D;

	// operation selector carried on s_tuser
	localparam logic ACT_MUL = 1'b0;
	localparam logic ACT_INV = 1'b1;

	// result status codes
	localparam logic [1:0] STAT_OK          = 2'd0;
	localparam logic [1:0] STAT_NOT_COPRIME = 2'd1;
	localparam logic [1:0] STAT_MOD_ZERO    = 2'd2;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_B,
		ST_MUL_A,
		ST_ALIGN,
		ST_EUC,
		ST_DONE
	} gf2m_fmi_state_t;

endpackage

// File: rtl/core/gf2m_field_mul_inverse_core.sv
// gf2m modular multiply and inverse core with apb modulus register
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-------------------------------------
//  s_*      | in        | s_tvalid / s_tready    | tuser: action; tdata: operand_a, operand_b
//  m_*      | out       | m_tvalid / m_tready    | tdata: result, status
//  apb      | in        | psel, penable, pready  | field_modulus at byte address 0
//
// one item is worked at a time under a small sequencer. multiply: 2*WIDTH steps
// on a shared shift/xor unit (bit-serial reduction of operand_b, then msb-first
// shift-and-add of operand_a). inverse: left-aligned extended euclid, one shift,
// xor or swap per cycle; zero modulus, modulus one and inverse of zero skip to done.
// s_tready is high only while idle; a finished result waits in the output
// register, so the next transaction may be taken while m_tready is low.
// arst_n resets the sequencer, the output valid and the modulus register.
module gf2m_field_mul_inverse_core #(
	parameter int WIDTH = 32,
	localparam int IN_W  = ((2 * WIDTH + 7) / 8) * 8,
	localparam int OUT_W = ((WIDTH + 2 + 7) / 8) * 8
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// input stream
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// operand_a [WIDTH-1:0], operand_b [2*WIDTH-1:WIDTH], zero fill above
	input  logic [IN_W-1:0]                        s_tdata,
	// action [0]
	input  logic                                   s_tuser,
	// output stream
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// result [WIDTH-1:0], status [WIDTH+1:WIDTH], zero fill above
	output logic [OUT_W-1:0]                       m_tdata,
	// configuration port
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [gf2m_fmi_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [gf2m_fmi_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [gf2m_fmi_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                                   pready
);

	import gf2m_fmi_pkg::*;

	localparam int MW = WIDTH + 1;
	localparam int SW = 2 * WIDTH + 1;
	localparam int CW = $clog2(WIDTH);
	localparam int DW = $clog2(WIDTH + 1);
	localparam logic [MW-1:0] MOD_RST = MW'(MOD_RESET);

	// one-hot of the highest set coefficient
	function automatic logic [MW-1:0] top_bit(input logic [MW-1:0] x);
		logic [MW-1:0] s;
		s = x;
		for (int k = 1; k < MW; k = k * 2) begin
			s = s | (s >> k);
		end
		return s & ~(s >> 1);
	endfunction

	gf2m_fmi_state_t state_q, state_d;

	logic [MW-1:0]    m_q;
	logic [MW-1:0]    mtop_q;
	logic [WIDTH-1:0] opa_q, opb_q;
	logic [MW-1:0]    w_q, bred_q;
	logic [CW-1:0]    cnt_q;
	logic [MW-1:0]    ra_q, rb_q;
	logic [DW-1:0]    da_q, db_q;
	logic [SW-1:0]    sa_q, sb_q;
	logic [WIDTH-1:0] res_q;
	logic [1:0]       stat_q;
	logic             out_valid_q;
	logic [WIDTH-1:0] out_res_q;
	logic [1:0]       out_stat_q;

	logic             in_xact;
	logic             load_out;
	logic             in_act;
	logic [WIDTH-1:0] in_a, in_b;
	logic [MW-1:0]    u_add, u_sum, u_out;
	logic             ra_nz;

	// input fields
	assign in_act = s_tuser;
	assign in_a   = s_tdata[WIDTH-1:0];
	assign in_b   = s_tdata[2*WIDTH-1:WIDTH];

	assign s_tready = (state_q == ST_IDLE);
	assign in_xact  = s_tvalid && s_tready;
	assign ra_nz    = |ra_q;

	// shared unit: multiply by x, add, fold back once by the modulus
	always_comb begin
		if (state_q == ST_MUL_A) begin
			u_add = opa_q[WIDTH-1] ? bred_q : '0;
		end else begin
			u_add = MW'(opb_q[WIDTH-1]);
		end
		u_sum = {w_q[WIDTH-1:0], 1'b0} ^ u_add;
		u_out = (|(u_sum & mtop_q)) ? (u_sum ^ m_q) : u_sum;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and output load
	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xact) begin
					if (m_q == '0 || m_q == MW'(1) || (in_act == ACT_INV && in_a == '0)) begin
						state_d = ST_DONE;
					end else if (in_act == ACT_MUL) begin
						state_d = ST_MUL_B;
					end else begin
						state_d = ST_ALIGN;
					end
				end
			end
			ST_MUL_B: begin
				if (cnt_q == '0) begin
					state_d = ST_MUL_A;
				end
			end
			ST_MUL_A: begin
				if (cnt_q == '0) begin
					state_d = ST_DONE;
				end
			end
			ST_ALIGN: begin
				if (ra_q[WIDTH] && rb_q[WIDTH]) begin
					state_d = ST_EUC;
				end
			end
			ST_EUC: begin
				if (!ra_nz) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xact) begin
					res_q  <= '0;
					stat_q <= (m_q == '0) ? STAT_MOD_ZERO : STAT_OK;
					opa_q  <= in_a;
					opb_q  <= in_b;
					w_q    <= '0;
					cnt_q  <= CW'(WIDTH - 1);
					mtop_q <= top_bit(m_q);
					ra_q   <= m_q;
					rb_q   <= {1'b0, in_a};
					da_q   <= DW'(WIDTH);
					db_q   <= DW'(WIDTH);
					sa_q   <= '0;
					sb_q   <= SW'(1);
				end
			end
			ST_MUL_B: begin
				opb_q <= opb_q << 1;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					bred_q <= u_out;
					w_q    <= '0;
					cnt_q  <= CW'(WIDTH - 1);
				end else begin
					w_q <= u_out;
				end
			end
			ST_MUL_A: begin
				opa_q <= opa_q << 1;
				cnt_q <= cnt_q - 1'b1;
				w_q   <= u_out;
				if (cnt_q == '0) begin
					res_q  <= u_out[WIDTH-1:0];
					stat_q <= STAT_OK;
				end
			end
			ST_ALIGN: begin
				// bring both leading coefficients to the top bit
				if (!ra_q[WIDTH]) begin
					ra_q <= ra_q << 1;
					sa_q <= sa_q << 1;
					da_q <= da_q - 1'b1;
				end
				if (!rb_q[WIDTH]) begin
					rb_q <= rb_q << 1;
					sb_q <= sb_q << 1;
					db_q <= db_q - 1'b1;
				end
			end
			ST_EUC: begin
				if (ra_nz && !ra_q[WIDTH]) begin
					// renormalize the remainder
					ra_q <= ra_q << 1;
					sa_q <= sa_q << 1;
					da_q <= da_q - 1'b1;
				end else if (ra_nz && da_q >= db_q) begin
					// cancel the leading coefficient
					ra_q <= ra_q ^ rb_q;
					sa_q <= sa_q ^ sb_q;
				end else if (ra_nz) begin
					// degree dropped below divisor: swap roles
					ra_q <= rb_q;
					rb_q <= ra_q;
					sa_q <= sb_q;
					sb_q <= sa_q;
					da_q <= db_q;
					db_q <= da_q;
				end else begin
					// remainder is zero, divisor holds the gcd
					if (db_q == '0) begin
						res_q  <= sb_q[2*WIDTH-1:WIDTH];
						stat_q <= STAT_OK;
					end else begin
						res_q  <= '0;
						stat_q <= STAT_NOT_COPRIME;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_res_q  <= res_q;
			out_stat_q <= stat_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'({out_stat_q, out_res_q});

	// modulus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q <= MOD_RST;
		end else if (psel && penable && pwrite && paddr[3] == REG_MODULUS) begin
			m_q <= pwdata[MW-1:0];
		end
	end

	// register read
	assign pready = 1'b1;
	assign prdata = (paddr[3] == REG_MODULUS) ? CFG_DATA_W'(m_q) : '0;

endmodule
